// File: rtl/core/hsi2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsi2rgb_pkg
// Shared types, constants and the cosine ratio table of the HSI to RGB path.
// ----------------------------------------------------------------------------
package hsi2rgb_pkg;

  localparam int HUE_BITS_DEF   = 12;
  localparam int COLOR_BITS_DEF = 8;

  // hue position: top SEG_BITS select a table segment
  localparam int SEG_BITS = 5;

  // cosine ratio, signed Q2.14
  localparam int Q_W = 17;
  localparam logic signed [Q_W-1:0] Q_ONE = 17'sd16384;

  // channel values, signed Q30 with headroom
  localparam int CH_W = 40;
  localparam int LEAD_SHIFT = 22;
  localparam int MIN_SHIFT  = 14;
  localparam int CLAMP_W    = 31;
  localparam logic [CLAMP_W-1:0] ONE_Q30 = 31'h4000_0000;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_SATURATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTENSITY  = 2'd1;
  localparam logic [CFG_DATA_W-1:0] CFG_RESET_VAL = 9'd256;

  localparam logic [1:0] SECTOR_RG = 2'd0;
  localparam logic [1:0] SECTOR_GB = 2'd1;

  // travels alongside each item down the pipe
  typedef struct packed {
    logic       valid;
    logic [1:0] sector;
  } tag_t;

  // cos(h)/cos(60-h) at 3.75 degree steps, Q2.14
  function automatic logic signed [Q_W-1:0] ratio_entry(input logic [5:0] idx);
    logic signed [Q_W-1:0] v;
    case (idx)
      6'd0:    v = 17'sd32768;
      6'd1:    v = 17'sd29427;
      6'd2:    v = 17'sd26683;
      6'd3:    v = 17'sd24371;
      6'd4:    v = 17'sd22381;
      6'd5:    v = 17'sd20635;
      6'd6:    v = 17'sd19080;
      6'd7:    v = 17'sd17673;
      6'd8:    v = 17'sd16384;
      6'd9:    v = 17'sd15189;
      6'd10:   v = 17'sd14069;
      6'd11:   v = 17'sd13008;
      6'd12:   v = 17'sd11994;
      6'd13:   v = 17'sd11014;
      6'd14:   v = 17'sd10060;
      6'd15:   v = 17'sd9122;
      6'd16:   v = 17'sd8192;
      6'd17:   v = 17'sd7262;
      6'd18:   v = 17'sd6324;
      6'd19:   v = 17'sd5370;
      6'd20:   v = 17'sd4390;
      6'd21:   v = 17'sd3375;
      6'd22:   v = 17'sd2315;
      6'd23:   v = 17'sd1195;
      6'd24:   v = 17'sd0;
      6'd25:   v = -17'sd1289;
      6'd26:   v = -17'sd2696;
      6'd27:   v = -17'sd4251;
      6'd28:   v = -17'sd5997;
      6'd29:   v = -17'sd7987;
      6'd30:   v = -17'sd10299;
      6'd31:   v = -17'sd13043;
      6'd32:   v = -17'sd16384;
      default: v = 17'sd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/hsi2rgb_ratio.sv
// ----------------------------------------------------------------------------
// hsi2rgb_ratio
// Stages 1-2: sector split of the hue and interpolated cosine ratio.
// ----------------------------------------------------------------------------
module hsi2rgb_ratio
  import hsi2rgb_pkg::*;
#(
  parameter int HUE_BITS = HUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [HUE_BITS-1:0]   hue,
  output tag_t                  tag_o,
  output logic signed [Q_W-1:0] q_o
);

  localparam int FB    = HUE_BITS - SEG_BITS;
  localparam int T_W   = HUE_BITS + 2;
  localparam int LO_W  = Q_W;
  localparam int DF_W  = Q_W + 1;
  localparam int NUM_W = Q_W + FB + 2;
  localparam logic signed [NUM_W-1:0] HALF = NUM_W'(1) <<< (FB - 1);

  logic [T_W-1:0]          t;
  logic [HUE_BITS-1:0]     pos;
  logic [5:0]              idx;
  logic signed [LO_W-1:0]  lo_next;
  logic signed [LO_W-1:0]  hi_next;

  // stage 1 registers
  tag_t                    tag1;
  logic signed [LO_W-1:0]  lo;
  logic signed [DF_W-1:0]  diff;
  logic [FB-1:0]           frac;

  logic signed [NUM_W-1:0] num;
  logic signed [Q_W-1:0]   q_next;

  // hue * 3: sector in the top two bits, position below
  always_comb begin
    t       = T_W'(hue) + (T_W'(hue) << 1);
    pos     = t[HUE_BITS-1:0];
    idx     = {1'b0, pos[HUE_BITS-1 -: SEG_BITS]};
    lo_next = ratio_entry(idx) + Q_ONE;
    hi_next = ratio_entry(idx + 6'd1) + Q_ONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.valid <= 1'b0;
    end else begin
      tag1.valid <= start;
    end
    tag1.sector <= t[T_W-1 -: 2];
    lo          <= lo_next;
    diff        <= DF_W'(hi_next) - DF_W'(lo_next);
    frac        <= pos[FB-1:0];
  end

  // linear interpolation, rounded to nearest with ties up; num is never negative
  always_comb begin
    num    = (NUM_W'(lo) <<< FB) + NUM_W'(diff) * NUM_W'($signed({1'b0, frac})) + HALF;
    q_next = $signed(num[FB +: Q_W]) - Q_ONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_o.valid <= 1'b0;
    end else begin
      tag_o.valid <= tag1.valid;
    end
    tag_o.sector <= tag1.sector;
    q_o          <= q_next;
  end

endmodule

// File: rtl/core/hsi2rgb_chan.sv
// ----------------------------------------------------------------------------
// hsi2rgb_chan
// Stages 3-4: minimum and leading channel products in Q30.
// ----------------------------------------------------------------------------
module hsi2rgb_chan
  import hsi2rgb_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  tag_t                    tag_i,
  input  logic signed [Q_W-1:0]   q_i,
  input  logic [CFG_DATA_W-1:0]   saturation,
  input  logic [CFG_DATA_W-1:0]   intensity,
  output tag_t                    tag_o,
  output logic signed [CH_W-1:0]  lead_o,
  output logic signed [CH_W-1:0]  minc_o
);

  localparam int SQ_W   = Q_W + CFG_DATA_W + 1;
  localparam int SD_W   = CFG_DATA_W + 2;
  localparam int M_W    = 2 * CFG_DATA_W + 3;
  localparam int LSUM_W = SQ_W + 1;
  localparam logic signed [LSUM_W-1:0] LEAD_BIAS = LSUM_W'(1) <<< LEAD_SHIFT;

  logic signed [CFG_DATA_W:0] s_sgn;
  logic signed [CFG_DATA_W:0] i_sgn;
  logic signed [SD_W-1:0]     sdiff;

  // stage 3 registers
  tag_t                       tag3;
  logic signed [SQ_W-1:0]     sq;
  logic signed [M_W-1:0]      m;

  logic signed [LSUM_W-1:0]   lsum;

  always_comb begin
    s_sgn = $signed({1'b0, saturation});
    i_sgn = $signed({1'b0, intensity});
    sdiff = $signed(SD_W'(256)) - SD_W'(s_sgn);
    lsum  = LSUM_W'(sq) + LEAD_BIAS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag3.valid <= 1'b0;
    end else begin
      tag3.valid <= tag_i.valid;
    end
    tag3.sector <= tag_i.sector;
    sq          <= SQ_W'(s_sgn) * SQ_W'(q_i);
    m           <= M_W'(i_sgn) * M_W'(sdiff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_o.valid <= 1'b0;
    end else begin
      tag_o.valid <= tag3.valid;
    end
    tag_o.sector <= tag3.sector;
    lead_o       <= CH_W'(i_sgn) * CH_W'(lsum);
    minc_o       <= CH_W'(m) <<< MIN_SHIFT;
  end

endmodule

// File: rtl/core/hsi2rgb_out.sv
// ----------------------------------------------------------------------------
// hsi2rgb_out
// Stages 5-6: third channel, sector routing, clamp and scale to colour bits.
// ----------------------------------------------------------------------------
module hsi2rgb_out
  import hsi2rgb_pkg::*;
#(
  parameter int COLOR_BITS = COLOR_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tag_t                   tag_i,
  input  logic signed [CH_W-1:0] lead_i,
  input  logic signed [CH_W-1:0] minc_i,
  input  logic [CFG_DATA_W-1:0]  intensity,
  output logic                   done,
  output logic [COLOR_BITS-1:0]  red,
  output logic [COLOR_BITS-1:0]  green,
  output logic [COLOR_BITS-1:0]  blue
);

  localparam int PW = CLAMP_W + COLOR_BITS;
  localparam logic [PW-1:0] HALF30 = PW'(1) << 29;

  function automatic logic [CLAMP_W-1:0] clamp(input logic signed [CH_W-1:0] x);
    logic [CLAMP_W-1:0] v;
    if (x < 0) begin
      v = '0;
    end else if (x > $signed(CH_W'(ONE_Q30))) begin
      v = ONE_Q30;
    end else begin
      v = x[CLAMP_W-1:0];
    end
    return v;
  endfunction

  // x * (2^COLOR_BITS - 1), rounded, over 2^30
  function automatic logic [COLOR_BITS-1:0] scale(input logic [CLAMP_W-1:0] x);
    logic [PW-1:0] p;
    p = (PW'(x) << COLOR_BITS) - PW'(x) + HALF30;
    return p[30 +: COLOR_BITS];
  endfunction

  logic [CH_W-1:0]        i3;
  logic signed [CH_W-1:0] third;
  logic signed [CH_W-1:0] r_raw, g_raw, b_raw;

  // stage 5 registers
  logic                   valid5;
  logic [CLAMP_W-1:0]     r_cl, g_cl, b_cl;

  always_comb begin
    i3    = (CH_W'(intensity) + (CH_W'(intensity) << 1)) << LEAD_SHIFT;
    third = $signed(i3) - lead_i - minc_i;
    case (tag_i.sector)
      SECTOR_RG: begin
        r_raw = lead_i;
        g_raw = third;
        b_raw = minc_i;
      end
      SECTOR_GB: begin
        r_raw = minc_i;
        g_raw = lead_i;
        b_raw = third;
      end
      default: begin
        r_raw = third;
        g_raw = minc_i;
        b_raw = lead_i;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid5 <= 1'b0;
    end else begin
      valid5 <= tag_i.valid;
    end
    r_cl <= clamp(r_raw);
    g_cl <= clamp(g_raw);
    b_cl <= clamp(b_raw);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid5;
    end
    red   <= scale(r_cl);
    green <= scale(g_cl);
    blue  <= scale(b_cl);
  end

endmodule

// File: rtl/core/hsi_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsi_to_rgb_converter
// Hue to RGB colour through the HSI model, saturation and intensity from
// configuration registers. Six-stage pipeline.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  -------   ---------------------   -------------------------------
//  input     start / busy            hue
//  result    done (one-cycle pulse)  red, green, blue
//  config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  One item per clock; busy stays low and cfg_ready stays high.
//  done and the colour are registered together in the last of the register
//  stages (table, interpolate, two multiply, clamp, scale).
//  Reset clears the valid bits and loads 1.0 into both registers.
//  The receiver cannot stall, so results leave as they come.
// ----------------------------------------------------------------------------
module hsi_to_rgb_converter
  import hsi2rgb_pkg::*;
#(
  parameter int HUE_BITS   = HUE_BITS_DEF,
  parameter int COLOR_BITS = COLOR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [HUE_BITS-1:0]   hue,
  output logic                  done,
  output logic [COLOR_BITS-1:0] red,
  output logic [COLOR_BITS-1:0] green,
  output logic [COLOR_BITS-1:0] blue,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CFG_DATA_W-1:0]  saturation;
  logic [CFG_DATA_W-1:0]  intensity;

  tag_t                   tag_q;
  logic signed [Q_W-1:0]  q;
  tag_t                   tag_ch;
  logic signed [CH_W-1:0] lead;
  logic signed [CH_W-1:0] minc;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      saturation <= CFG_RESET_VAL;
      intensity  <= CFG_RESET_VAL;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SATURATION: saturation <= cfg_data;
        REG_INTENSITY:  intensity  <= cfg_data;
        default: ;
      endcase
    end
  end

  hsi2rgb_ratio #(
    .HUE_BITS (HUE_BITS)
  ) u_ratio (
    .clk   (clk),
    .rst   (rst),
    .start (start && !busy),
    .hue   (hue),
    .tag_o (tag_q),
    .q_o   (q)
  );

  hsi2rgb_chan u_chan (
    .clk        (clk),
    .rst        (rst),
    .tag_i      (tag_q),
    .q_i        (q),
    .saturation (saturation),
    .intensity  (intensity),
    .tag_o      (tag_ch),
    .lead_o     (lead),
    .minc_o     (minc)
  );

  hsi2rgb_out #(
    .COLOR_BITS (COLOR_BITS)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .tag_i     (tag_ch),
    .lead_i    (lead),
    .minc_i    (minc),
    .intensity (intensity),
    .done      (done),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

endmodule

// File: test/hsi_to_rgb_converter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsi_to_rgb_converter_test
// Self-checking bench for the hue to RGB converter. Hues go in on the
// start/busy channel, and each colour that leaves on done is compared with a
// fixed-point prediction. The run steps through several saturation and
// intensity settings, the extremes and out-of-range values among them.
// ----------------------------------------------------------------------------
import hsi2rgb_pkg::*;

typedef struct packed {
  logic [COLOR_BITS_DEF-1:0] red;
  logic [COLOR_BITS_DEF-1:0] green;
  logic [COLOR_BITS_DEF-1:0] blue;
} color_t;

class color_scoreboard;
  logic [CFG_DATA_W-1:0] sat;
  logic [CFG_DATA_W-1:0] inten;
  longint                ratio_tab [33];
  color_t                expected_colors [$];
  int                    errors;
  int                    compared;

  function new();
    sat      = CFG_RESET_VAL;
    inten    = CFG_RESET_VAL;
    errors   = 0;
    compared = 0;
    // cos(h)/cos(60-h) in Q2.14, 3.75 degree steps
    ratio_tab = '{32768, 29427, 26683, 24371, 22381, 20635, 19080, 17673,
                  16384, 15189, 14069, 13008, 11994, 11014, 10060, 9122,
                  8192, 7262, 6324, 5370, 4390, 3375, 2315, 1195,
                  0, -1289, -2696, -4251, -5997, -7987, -10299, -13043,
                  -16384};
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (idx == REG_SATURATION) begin
      sat = val;
    end else if (idx == REG_INTENSITY) begin
      inten = val;
    end
  endfunction

  // clamp a Q30 channel to 0..1 and scale to the output width
  function logic [COLOR_BITS_DEF-1:0] to_level(longint x);
    longint cmax;
    cmax = (longint'(1) <<< COLOR_BITS_DEF) - 1;
    if (x < 0) x = 0;
    if (x > (longint'(1) <<< 30)) x = longint'(1) <<< 30;
    return COLOR_BITS_DEF'((x * cmax + (longint'(1) <<< 29)) >>> 30);
  endfunction

  function color_t predict_color(logic [HUE_BITS_DEF-1:0] h);
    int     fb;
    int     t;
    int     sector;
    int     pos;
    int     seg;
    longint frac;
    longint lo;
    longint hi;
    longint num;
    longint q;
    longint s;
    longint i;
    longint minc;
    longint lead;
    longint third;
    longint r;
    longint g;
    longint b;
    color_t c;
    fb     = HUE_BITS_DEF - SEG_BITS;
    t      = int'(h) * 3;
    sector = t >> HUE_BITS_DEF;
    pos    = t & ((1 << HUE_BITS_DEF) - 1);
    seg    = (pos >> fb) & 31;
    frac   = pos & ((1 << fb) - 1);
    // interpolate with the offset added so the shift sees a non-negative value
    lo  = ratio_tab[seg] + 16384;
    hi  = ratio_tab[seg + 1] + 16384;
    num = lo * (longint'(1) <<< fb) + (hi - lo) * frac;
    q   = ((num + (longint'(1) <<< (fb - 1))) >>> fb) - 16384;
    s     = sat;
    i     = inten;
    minc  = i * (256 - s) * 16384;
    lead  = i * (s * q + (longint'(1) <<< LEAD_SHIFT));
    third = 3 * i * (longint'(1) <<< LEAD_SHIFT) - lead - minc;
    case (2'(sector))
      SECTOR_RG: begin
        b = minc; r = lead; g = third;
      end
      SECTOR_GB: begin
        r = minc; g = lead; b = third;
      end
      default: begin
        g = minc; b = lead; r = third;
      end
    endcase
    c.red   = to_level(r);
    c.green = to_level(g);
    c.blue  = to_level(b);
    return c;
  endfunction

  function void note_hue(logic [HUE_BITS_DEF-1:0] h);
    expected_colors.push_back(predict_color(h));
  endfunction

  function void check_color(logic [COLOR_BITS_DEF-1:0] r, logic [COLOR_BITS_DEF-1:0] g,
                            logic [COLOR_BITS_DEF-1:0] b);
    color_t want;
    if (expected_colors.size() == 0) begin
      $error("colour with no item outstanding: red %0d green %0d blue %0d", r, g, b);
      errors++;
      return;
    end
    want = expected_colors.pop_front();
    compared++;
    if (r !== want.red) begin
      $error("red: expected %0d, got %0d", want.red, r);
      errors++;
    end
    if (g !== want.green) begin
      $error("green: expected %0d, got %0d", want.green, g);
      errors++;
    end
    if (b !== want.blue) begin
      $error("blue: expected %0d, got %0d", want.blue, b);
      errors++;
    end
  endfunction
endclass

module hsi_to_rgb_converter_test;

  localparam int PIPE_DEPTH    = 6;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 216;
  localparam logic [CFG_IDX_W-1:0] UNUSED_REG_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] UNUSED_REG_HI = 2'd3;
  localparam int SECTOR_SPAN   = (1 << HUE_BITS_DEF) / 3;

  logic                      clk;
  logic                      rst       = 1'b1;
  logic                      start     = 1'b0;
  logic                      busy;
  logic [HUE_BITS_DEF-1:0]   hue       = '0;
  logic                      done;
  logic [COLOR_BITS_DEF-1:0] red;
  logic [COLOR_BITS_DEF-1:0] green;
  logic [COLOR_BITS_DEF-1:0] blue;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data  = '0;

  color_scoreboard sb = new();
  int              idle_cycles = 0;
  int              hues_sent   = 0;
  int              settings    = 1;

  hsi_to_rgb_converter dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .hue       (hue),
    .done      (done),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if (start && !busy) sb.note_hue(hue);
      if (done) sb.check_color(red, green, blue);
      if ((cfg_valid && cfg_ready) || (start && !busy) || done) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("Timed out: nothing moved for %0d cycles", STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // start is left high so that back-to-back items follow with no gap
  task automatic drive_hue(logic [HUE_BITS_DEF-1:0] h, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    hue   <= h;
    @(posedge clk);
    while (busy) @(posedge clk);
    hues_sent++;
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_colors.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  // the spare index must leave both levels alone
  task automatic set_levels(logic [CFG_DATA_W-1:0] s, logic [CFG_DATA_W-1:0] i);
    cfg_write(REG_SATURATION, s);
    cfg_write($urandom_range(0, 1) ? UNUSED_REG_LO : UNUSED_REG_HI,
              CFG_DATA_W'($urandom));
    cfg_write(REG_INTENSITY, i);
    cfg_valid <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CFG_RESET_VAL;
      2:       return '1;
      3:       return CFG_DATA_W'($urandom_range(257, 511));
      default: return CFG_DATA_W'($urandom_range(0, 256));
    endcase
  endfunction

  function automatic logic [HUE_BITS_DEF-1:0] pick_hue();
    int edge_hue;
    if ($urandom_range(0, 7) == 0) begin
      // near a sector or table boundary
      edge_hue = SECTOR_SPAN * $urandom_range(0, 3) + $urandom_range(0, 4) - 2;
      return HUE_BITS_DEF'(edge_hue);
    end
    return HUE_BITS_DEF'($urandom);
  endfunction

  initial begin
    logic [HUE_BITS_DEF-1:0] directed_hues [$];
    logic [CFG_DATA_W-1:0]   fixed_sat [5];
    logic [CFG_DATA_W-1:0]   fixed_int [5];
    int                      gap;

    directed_hues = '{12'h000, 12'hFFF, 12'h001, 12'hFFE, 12'h07F, 12'h080,
                      12'h554, 12'h555, 12'h556, 12'h557, 12'hAA9, 12'hAAA,
                      12'hAAB, 12'hAAC, 12'h2AA, 12'h7FF, 12'h800, 12'hD55,
                      12'hA5A, 12'h5A5, 12'h333, 12'hCCC, 12'h0F0, 12'hF0F};
    fixed_sat = '{9'd0, 9'd256, 9'd511, 9'd0, 9'd511};
    fixed_int = '{9'd256, 9'd0, 9'd511, 9'd0, 9'd128};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset levels first: full saturation, full intensity
    foreach (directed_hues[k]) drive_hue(directed_hues[k], 0);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 5) begin
        set_levels(fixed_sat[ph], fixed_int[ph]);
      end else begin
        set_levels(pick_level(), pick_level());
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        gap = 0;
        // the final phase runs flat out
        if (ph < PHASES - 1 && (n % 64) < 40 && $urandom_range(0, 3) == 0) begin
          gap = $urandom_range(1, 7);
        end
        drive_hue(pick_hue(), gap);
      end
      settle();
    end

    $display("Sent %0d hues over %0d saturation/intensity settings, checked %0d colours.",
             hues_sent, settings, sb.compared);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
